>>> hw/rtl/product_quant_distance_assert.svh
// Assertion macros for the product quantizer distance checker.
// Depends on nothing; included by the checker file.
`ifndef PRODUCT_QUANT_DISTANCE_ASSERT_SVH
`define PRODUCT_QUANT_DISTANCE_ASSERT_SVH

// same-cycle implication
`define PQD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pqd check failed");

// next-cycle implication
`define PQD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pqd check failed");

`endif

>>> hw/rtl/pqd_pkg.sv
// Shared types and constants of the product quantizer distance block.
// No dependencies.
`default_nettype none
package pqd_pkg;

   localparam int VALUE_W    = 16;
   localparam int SQ_W       = 32;
   localparam int SUM_W      = 39;
   localparam int RUN_W      = 40;
   localparam int SUB_DIMS_W = 5;
   localparam int EPOCH_W    = 8;
   localparam int SUB_IDX_W  = 3;
   localparam int CLU_W      = 8;
   localparam int DIM_W      = 4;
   localparam logic [SUB_DIMS_W-1:0] SUB_DIMS_RESET = 5'd16;
   localparam logic [RUN_W-1:0]      SUM_MAX = {1'b0, {SUM_W{1'b1}}};

   typedef enum logic [1:0] {
      ACT_CENT  = 2'd0,
      ACT_QUERY = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_CODE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_LOOKUP,
      ST_MAC,
      ST_SUM
   } state_type;

   // control from sequencer to the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic issue;
   } mac_ctl_type;

endpackage
`default_nettype wire

>>> hw/rtl/pqd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module pqd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

>>> hw/rtl/pqd_mac.sv
// Difference, square and accumulate unit for one subvector distance.
// Depends on pqd_pkg.
`default_nettype none
module pqd_mac #(
   parameter int ACC_W = 37
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire pqd_pkg::mac_ctl_type         ctl,
   input  wire logic [pqd_pkg::VALUE_W-1:0]  query_data,
   input  wire logic [pqd_pkg::VALUE_W-1:0]  cent_data,
   output logic                              busy,
   output logic      [ACC_W-1:0]             acc
);
   import pqd_pkg::*;

   logic                     rd_v_ff, sq_v_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic [ACC_W-1:0]         acc_ff;
   logic signed [VALUE_W:0]  diff;
   logic signed [2*VALUE_W+1:0] prod;

   // RAM data arrives in the cycle after issue
   assign diff = $signed({query_data[VALUE_W-1], query_data})
               - $signed({cent_data[VALUE_W-1], cent_data});
   assign prod = diff * diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         sq_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= ctl.issue;
         sq_v_ff <= rd_v_ff;
      end
   end

   // square register, then accumulate
   always_ff @(posedge clock) begin
      sq_ff <= prod[SQ_W-1:0];
      if (ctl.clear) begin
         acc_ff <= '0;
      end else if (sq_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(sq_ff);
      end
   end

   assign busy = rd_v_ff | sq_v_ff;
   assign acc  = acc_ff;
endmodule
`default_nettype wire

>>> hw/rtl/product_quant_distance.sv
// Top level of the product quantizer asymmetric distance block.
// Depends on pqd_pkg, pqd_ram and pqd_mac.
//
// Usage: items arrive on the req_ channel (valid/stall). Centroid and query
// element writes, and cache clears, complete in the idle state unless the epoch
// wraps. A code item looks up the distance cache: a hit passes through the
// lookup and sum steps, a miss also through a MAC step in which the single
// multiply-accumulate walks the centroid and query RAMs one element per cycle.
// A code item marked last loads the summed distance into the rsp_ output
// register; the block accepts new items while that result waits. If the receiver
// stalls and a second total is ready, the block holds in its sum step until the
// register is free. Cache marks are epoch tags stored with each cached distance;
// a clear or a query write bumps the epoch. After reset, and each time the epoch
// wraps (every 255 clears or query writes), a sweep over all NUM_SUB*NUM_CLUSTERS
// cache entries (2048 by default) retags the cache while req_stall stays high.
// csr_ writes are taken in any cycle. Reset is synchronous and active high.
`default_nettype none
module product_quant_distance #(
   parameter int NUM_SUB      = 8,
   parameter int MAX_SUB_DIMS = 16,
   parameter int NUM_CLUSTERS = 256
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [1:0]                        req_action,
   input  wire logic [pqd_pkg::SUB_IDX_W-1:0]     req_sub_index,
   input  wire logic [pqd_pkg::CLU_W-1:0]         req_cluster,
   input  wire logic [pqd_pkg::DIM_W-1:0]         req_dim_index,
   input  wire logic signed [pqd_pkg::VALUE_W-1:0] req_value,
   input  wire logic                              req_last,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [pqd_pkg::SUM_W-1:0]         rsp_distance_sq,
   input  wire logic                              csr_wr_en,
   input  wire logic [pqd_pkg::SUB_DIMS_W-1:0]    csr_wr_data
);
   import pqd_pkg::*;

   localparam int CACHE_D = NUM_SUB * NUM_CLUSTERS;
   localparam int CA_W    = $clog2(CACHE_D);
   localparam int CENT_D  = CACHE_D * MAX_SUB_DIMS;
   localparam int CE_W    = $clog2(CENT_D);
   localparam int QRY_D   = NUM_SUB * MAX_SUB_DIMS;
   localparam int QA_W    = (QRY_D > 1) ? $clog2(QRY_D) : 1;
   localparam int CNT_W   = $clog2(MAX_SUB_DIMS + 1);
   localparam int ACC_W   = SQ_W + $clog2(MAX_SUB_DIMS + 1);
   localparam int CW      = ACC_W + EPOCH_W;

   state_type state_ff, state_in;
   logic [SUB_DIMS_W-1:0] sub_dims_ff;
   logic [EPOCH_W-1:0]    epoch_ff, epoch_in;
   logic [CA_W-1:0]       sweep_ff, sweep_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [CA_W-1:0]       slot_ff, slot_in;
   logic [SUB_IDX_W-1:0]  sub_ff, sub_in;
   logic                  ok_ff, ok_in, last_ff, last_in;
   logic [ACC_W-1:0]      dist_ff, dist_in;
   logic [RUN_W-1:0]      run_ff, run_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]      rsp_data_ff, rsp_data_in;

   logic              accept, sub_ok, clu_ok, dim_ok, out_free;
   logic [CA_W-1:0]   req_slot;
   logic [CNT_W-1:0]  dims_n;
   logic [RUN_W-1:0]  sum_raw, sum_sat;
   logic              hit, mac_done;

   logic              cent_we, query_we, cache_we;
   logic [CE_W-1:0]   cent_wa, cent_ra;
   logic [QA_W-1:0]   query_wa, query_ra;
   logic [CA_W-1:0]   cache_wa;
   logic [CW-1:0]     cache_wd, cache_rd;
   logic [VALUE_W-1:0] cent_rd, query_rd;
   mac_ctl_type       mac_ctl;
   logic              mac_busy;
   logic [ACC_W-1:0]  mac_acc;

   // handshake and address decode
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign sub_ok    = 32'(req_sub_index) < NUM_SUB;
   assign clu_ok    = 32'(req_cluster) < NUM_CLUSTERS;
   assign dim_ok    = 32'(req_dim_index) < MAX_SUB_DIMS;
   assign req_slot  = CA_W'(32'(req_sub_index) * NUM_CLUSTERS + 32'(req_cluster));

   // dimensions in use, clamped to 1..MAX_SUB_DIMS
   always_comb begin
      if (sub_dims_ff == '0) begin
         dims_n = CNT_W'(1);
      end else if (32'(sub_dims_ff) > MAX_SUB_DIMS) begin
         dims_n = CNT_W'(MAX_SUB_DIMS);
      end else begin
         dims_n = CNT_W'(sub_dims_ff);
      end
   end

   assign hit      = (cache_rd[CW-1 -: EPOCH_W] == epoch_ff);
   assign mac_done = (cnt_ff == dims_n) & ~mac_busy;
   assign sum_raw  = run_ff + RUN_W'(dist_ff);
   assign sum_sat  = (sum_raw > SUM_MAX) ? SUM_MAX : sum_raw;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            if (sweep_ff == CA_W'(CACHE_D - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_CODE) begin
                  state_in = ST_LOOKUP;
               end else if ((req_action == ACT_QUERY || req_action == ACT_CLEAR)
                            && epoch_ff == '1) begin
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_LOOKUP: begin
            state_in = (ok_ff && !hit) ? ST_MAC : ST_SUM;
         end
         ST_MAC: begin
            if (mac_done) state_in = ST_SUM;
         end
         ST_SUM: begin
            if (!last_ff || out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      epoch_in     = epoch_ff;
      sweep_in     = sweep_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      sub_in       = sub_ff;
      ok_in        = ok_ff;
      last_in      = last_ff;
      dist_in      = dist_ff;
      run_in       = run_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cent_we      = 1'b0;
      query_we     = 1'b0;
      cache_we     = 1'b0;
      cache_wa     = slot_ff;
      cache_wd     = {epoch_ff, mac_acc};
      mac_ctl      = '0;
      cent_wa      = CE_W'(32'(req_slot) * MAX_SUB_DIMS + 32'(req_dim_index));
      query_wa     = QA_W'(32'(req_sub_index) * MAX_SUB_DIMS + 32'(req_dim_index));
      cent_ra      = CE_W'(32'(slot_ff) * MAX_SUB_DIMS + 32'(cnt_ff));
      query_ra     = QA_W'(32'(sub_ff) * MAX_SUB_DIMS + 32'(cnt_ff));
      unique case (state_ff)
         ST_SWEEP: begin
            cache_we = 1'b1;
            cache_wa = sweep_ff;
            cache_wd = '0;
            sweep_in = sweep_ff + CA_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action) inside
                  ACT_CENT: cent_we = sub_ok & clu_ok & dim_ok;
                  ACT_QUERY, ACT_CLEAR: begin
                     query_we = (req_action == ACT_QUERY) & sub_ok & dim_ok;
                     if (req_action == ACT_CLEAR) run_in = '0;
                     if (epoch_ff == '1) begin
                        epoch_in = EPOCH_W'(1);
                        sweep_in = '0;
                     end else begin
                        epoch_in = epoch_ff + EPOCH_W'(1);
                     end
                  end
                  ACT_CODE: begin
                     slot_in = req_slot;
                     sub_in  = req_sub_index;
                     ok_in   = sub_ok & clu_ok;
                     last_in = req_last;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOOKUP: begin
            cnt_in        = '0;
            mac_ctl.clear = 1'b1;
            dist_in       = ok_ff ? cache_rd[ACC_W-1:0] : '0;
         end
         ST_MAC: begin
            if (cnt_ff != dims_n) begin
               mac_ctl.issue = 1'b1;
               cnt_in        = cnt_ff + CNT_W'(1);
            end
            if (mac_done) begin
               cache_we = 1'b1;
               dist_in  = mac_acc;
            end
         end
         ST_SUM: begin
            if (!last_ff) begin
               run_in = sum_sat;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sum_sat[SUM_W-1:0];
               run_in       = '0;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         epoch_ff     <= EPOCH_W'(1);
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         sub_dims_ff  <= SUB_DIMS_RESET;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         epoch_ff     <= epoch_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) sub_dims_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      slot_ff     <= slot_in;
      sub_ff      <= sub_in;
      ok_ff       <= ok_in;
      last_ff     <= last_in;
      dist_ff     <= dist_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_distance_sq = rsp_data_ff;

   pqd_ram #(.WIDTH(VALUE_W), .DEPTH(CENT_D)) u_cent_ram (
      .clock   (clock),
      .wr_en   (cent_we),
      .wr_addr (cent_wa),
      .wr_data (req_value),
      .rd_addr (cent_ra),
      .rd_data (cent_rd)
   );

   pqd_ram #(.WIDTH(VALUE_W), .DEPTH(QRY_D)) u_query_ram (
      .clock   (clock),
      .wr_en   (query_we),
      .wr_addr (query_wa),
      .wr_data (req_value),
      .rd_addr (query_ra),
      .rd_data (query_rd)
   );

   pqd_ram #(.WIDTH(CW), .DEPTH(CACHE_D)) u_cache_ram (
      .clock   (clock),
      .wr_en   (cache_we),
      .wr_addr (cache_wa),
      .wr_data (cache_wd),
      .rd_addr (req_slot),
      .rd_data (cache_rd)
   );

   pqd_mac #(.ACC_W(ACC_W)) u_mac (
      .clock      (clock),
      .reset      (reset),
      .ctl        (mac_ctl),
      .query_data (query_rd),
      .cent_data  (cent_rd),
      .busy       (mac_busy),
      .acc        (mac_acc)
   );
endmodule
`default_nettype wire

>>> hw/rtl/pqd_checker.sv
// Port-level checks of the product quantizer distance block, bound to it.
// Depends on pqd_pkg and product_quant_distance_assert.svh.
`default_nettype none
`include "product_quant_distance_assert.svh"
module pqd_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic [1:0]                        req_action,
   input wire logic [pqd_pkg::SUB_IDX_W-1:0]     req_sub_index,
   input wire logic [pqd_pkg::CLU_W-1:0]         req_cluster,
   input wire logic [pqd_pkg::DIM_W-1:0]         req_dim_index,
   input wire logic signed [pqd_pkg::VALUE_W-1:0] req_value,
   input wire logic                              req_last,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [pqd_pkg::SUM_W-1:0]         rsp_distance_sq,
   input wire logic                              csr_wr_en,
   input wire logic [pqd_pkg::SUB_DIMS_W-1:0]    csr_wr_data
);
   import pqd_pkg::*;

   logic req_xfer;
   assign req_xfer = req_valid & ~req_stall;

   // a result holds until transferred
   `PQD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   // a code item leaves the input stalled after it is accepted
   `PQD_ASSERT_NEXT(a_code_busy, clock, reset, req_xfer && req_action == ACT_CODE, req_stall)
   // the cache sweep after reset stalls the input
   `PQD_ASSERT_NEXT(a_reset_sweep, clock, 1'b0, reset, req_stall && !rsp_valid)
   // writes and clears never produce a result
   `PQD_ASSERT_NEXT(a_no_spurious, clock, reset,
                    req_xfer && req_action != ACT_CODE && !rsp_valid, !rsp_valid)
endmodule

bind product_quant_distance pqd_checker u_pqd_checker (.*);
`default_nettype wire
